// ----- rtl/calendar_time_add_subtract_unit_macros.svh -----
`ifndef CALENDAR_TIME_ADD_SUBTRACT_UNIT_MACROS_SVH
`define CALENDAR_TIME_ADD_SUBTRACT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on every rising edge outside reset.
// The module that uses it must have clk and arst_n in scope.
`define CTA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CTA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/cta_pkg.sv -----
package cta_pkg;

	// Interval unit codes.
	localparam logic [1:0] UNIT_MINUTES = 2'd0;
	localparam logic [1:0] UNIT_HOURS   = 2'd1;
	localparam logic [1:0] UNIT_DAYS    = 2'd2;
	localparam logic [1:0] UNIT_MONTHS  = 2'd3;

	// Direction codes.
	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_SUB = 1'b1;

	// Days per month in a common year, January first.
	localparam logic [4:0] DAYS_PER_MONTH [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// Request transaction.
	typedef struct packed {
		logic        mode;
		logic [1:0]  unit;
		logic [15:0] interval;
		logic [5:0]  start_minute;
		logic [4:0]  start_hour;
		logic [4:0]  start_day;
		logic [3:0]  start_month;
		logic [6:0]  start_year;
	} cta_cmd_t;

	// Result transaction.
	typedef struct packed {
		logic [5:0] new_minute;
		logic [4:0] new_hour;
		logic [4:0] new_day;
		logic [3:0] new_month;
		logic [6:0] new_year;
		logic       start_valid;
		logic       range_error;
	} cta_res_t;

	// Calendar time as it moves through the stepping stages. The day keeps
	// one extra bit because a day step can briefly pass 31.
	typedef struct packed {
		logic [5:0] minute;
		logic [4:0] hour;
		logic [5:0] day;
		logic [3:0] month;
		logic [6:0] year;
	} cta_time_t;

	// Start time plus the interval taken apart into calendar fields.
	// The year part travels as its quotient by 12 and that value's
	// hundreds, so the remainder by 100 is formed in the first stepping stage.
	typedef struct packed {
		logic        mode;
		logic        apply;
		logic        start_valid;
		logic        range_error;
		cta_time_t   tm;
		logic [5:0]  part_minute;
		logic [4:0]  part_hour;
		logic [4:0]  part_day;
		logic [3:0]  part_month;
		logic [12:0] year_quo;
		logic [6:0]  year_hun;
	} cta_work_t;

	// Length of a month; years 2000 to 2099 are leap exactly when the
	// offset is a multiple of four (2000 itself is a leap year).
	function automatic logic [4:0] month_len(input logic [3:0] month, input logic [6:0] year);
		logic [3:0] idx;
		logic [4:0] len;
		idx = (month >= 4'd1 && month <= 4'd12) ? month - 4'd1 : 4'd0;
		len = DAYS_PER_MONTH[idx];
		if (idx == 4'd1 && year[1:0] == 2'b00) begin
			len = 5'd29;
		end
		return len;
	endfunction

endpackage

// ----- rtl/cta_split.sv -----
`include "calendar_time_add_subtract_unit_macros.svh"

module cta_split (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  cta_pkg::cta_cmd_t  cmd,
	output logic               work_valid,
	input  logic               work_stall,
	output cta_pkg::cta_work_t work
);
	import cta_pkg::*;

	// Reciprocals for exact division of a 16-bit value by a constant:
	// ceil(2^s / d) with s = 16 + ceil(log2 d).
	localparam logic [16:0] RCP_1440 = 17'd93207;  // s = 27
	localparam logic [16:0] RCP_24   = 17'd87382;  // s = 21
	localparam logic [16:0] RCP_31   = 17'd67651;  // s = 21
	localparam logic [16:0] RCP_12   = 17'd87382;  // s = 20
	localparam logic [16:0] RCP_60   = 17'd69906;  // s = 22
	// Exact for a 13-bit value divided by 100, s = 20.
	localparam logic [13:0] RCP_100  = 14'd10486;

	logic        v_s1;
	logic        v_s2;
	logic        en_s1;
	logic        en_s2;
	cta_cmd_t    cmd_s1;
	logic [12:0] quo_s1;
	logic [10:0] q60_s1;
	logic        ok_s1;
	cta_work_t   work_s2;

	logic [32:0] prod_1440;
	logic [32:0] prod_24;
	logic [32:0] prod_31;
	logic [32:0] prod_12;
	logic [32:0] prod_60;
	logic [12:0] quo_next;
	logic        start_ok;

	logic [15:0] rem_60;
	logic [10:0] hour_min;
	logic [15:0] rem_24;
	logic [15:0] rem_31;
	logic [15:0] rem_12;
	logic [5:0]  part_minute;
	logic [4:0]  part_hour;
	logic [11:0] day_full;
	logic [11:0] month_full;
	logic [12:0] year_quo;
	logic [26:0] hun_prod;
	logic        range_err;
	cta_work_t   work_next;

	// Stage enables: a stage loads when it is empty or its successor moves.
	assign en_s2     = !v_s2 || !work_stall;
	assign en_s1     = !v_s1 || en_s2;
	assign cmd_stall = !en_s1;

	// Stage 1: quotient of the interval by the unit's divisor, and by 60.
	assign prod_1440 = {17'd0, cmd.interval} * {16'd0, RCP_1440};
	assign prod_24   = {17'd0, cmd.interval} * {16'd0, RCP_24};
	assign prod_31   = {17'd0, cmd.interval} * {16'd0, RCP_31};
	assign prod_12   = {17'd0, cmd.interval} * {16'd0, RCP_12};
	assign prod_60   = {17'd0, cmd.interval} * {16'd0, RCP_60};

	always_comb begin
		unique case (cmd.unit)
			UNIT_MINUTES: quo_next = {7'd0, prod_1440[32:27]};
			UNIT_HOURS:   quo_next = {1'b0, prod_24[32:21]};
			UNIT_DAYS:    quo_next = {1'b0, prod_31[32:21]};
			UNIT_MONTHS:  quo_next = prod_12[32:20];
		endcase
	end

	// A 5-bit day can never exceed 31, so only the lower bound is checked.
	assign start_ok = (cmd.start_minute < 6'd60) && (cmd.start_hour < 5'd24) &&
		(cmd.start_day != 5'd0) && (cmd.start_month >= 4'd1) &&
		(cmd.start_month <= 4'd12) && (cmd.start_year <= 7'd99);

	// Stage 2: remainders give the lower parts of the interval.
	assign rem_60   = cmd_s1.interval - ({5'd0, q60_s1} * 16'd60);
	assign hour_min = q60_s1 - (quo_s1[10:0] * 11'd24);
	assign rem_24   = cmd_s1.interval - ({3'd0, quo_s1} * 16'd24);
	assign rem_31   = cmd_s1.interval - ({3'd0, quo_s1} * 16'd31);
	assign rem_12   = cmd_s1.interval - ({3'd0, quo_s1} * 16'd12);

	always_comb begin
		part_minute = '0;
		part_hour   = '0;
		day_full    = '0;
		month_full  = '0;
		year_quo    = '0;
		unique case (cmd_s1.unit)
			UNIT_MINUTES: begin
				part_minute = rem_60[5:0];
				part_hour   = hour_min[4:0];
				day_full    = quo_s1[11:0];
			end
			UNIT_HOURS: begin
				part_hour = rem_24[4:0];
				day_full  = quo_s1[11:0];
			end
			UNIT_DAYS: begin
				day_full   = rem_31[11:0];
				month_full = quo_s1[11:0];
			end
			UNIT_MONTHS: begin
				month_full = rem_12[11:0];
				year_quo   = quo_s1;
			end
		endcase
	end

	// Hundreds of the year part, for its remainder by 100 downstream.
	assign hun_prod = {14'd0, year_quo} * {13'd0, RCP_100};

	// Per-field limits on the interval: the day limit depends on the direction, the month limit does not.
	assign range_err = ((cmd_s1.mode == MODE_SUB) ? (day_full > 12'd28) : (day_full >= 12'd31)) ||
		(month_full > 12'd12);

	always_comb begin
		work_next.mode        = cmd_s1.mode;
		work_next.apply       = ok_s1 && !range_err;
		work_next.start_valid = ok_s1;
		work_next.range_error = range_err;
		work_next.tm.minute   = cmd_s1.start_minute;
		work_next.tm.hour     = cmd_s1.start_hour;
		work_next.tm.day      = {1'b0, cmd_s1.start_day};
		work_next.tm.month    = cmd_s1.start_month;
		work_next.tm.year     = cmd_s1.start_year;
		work_next.part_minute = part_minute;
		work_next.part_hour   = part_hour;
		work_next.part_day    = day_full[4:0];
		work_next.part_month  = month_full[3:0];
		work_next.year_quo    = year_quo;
		work_next.year_hun    = hun_prod[26:20];
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= cmd_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			cmd_s1 <= cmd;
			quo_s1 <= quo_next;
			q60_s1 <= prod_60[32:22];
			ok_s1  <= start_ok;
		end
		if (en_s2) begin
			work_s2 <= work_next;
		end
	end

	assign work_valid = v_s2;
	assign work       = work_s2;

	`CTA_ASSERT_NOW(a_minute_split, v_s1 && cmd_s1.unit == UNIT_MINUTES, rem_60 < 16'd60 && hour_min < 11'd24 && quo_s1 < 13'd46, "minute interval split out of range")
	`CTA_ASSERT_NOW(a_hour_split, v_s1 && cmd_s1.unit == UNIT_HOURS, rem_24 < 16'd24, "hour interval remainder out of range")
	`CTA_ASSERT_NOW(a_day_split, v_s1 && cmd_s1.unit == UNIT_DAYS, rem_31 < 16'd31, "day interval remainder out of range")

endmodule

// ----- rtl/cta_step.sv -----
`include "calendar_time_add_subtract_unit_macros.svh"

module cta_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               work_valid,
	output logic               work_stall,
	input  cta_pkg::cta_work_t work,
	output logic               res_valid,
	input  logic               res_stall,
	output cta_pkg::cta_res_t  res
);
	import cta_pkg::*;

	// What each stepping stage hands to the next.
	typedef struct packed {
		logic       mode;
		logic       apply;
		logic       start_valid;
		logic       range_error;
		logic       carry;
		cta_time_t  tm;
		logic [4:0] part_day;
		logic [3:0] part_month;
		logic [6:0] year_rem;
	} cta_stage_t;

	logic       v_s1;
	logic       v_s2;
	logic       v_s3;
	logic       v_s4;
	logic       en_s1;
	logic       en_s2;
	logic       en_s3;
	logic       en_s4;
	cta_stage_t st_s1;
	cta_stage_t st_s2;
	cta_stage_t st_s3;
	cta_res_t   res_s4;

	cta_stage_t  st1_next;
	cta_stage_t  st2_next;
	cta_stage_t  st3_next;
	cta_res_t    res_next;

	logic [6:0]  min_sum;
	logic        min_wrap;
	logic [6:0]  min_add;
	logic [5:0]  hr_sum;
	logic        hr_wrap;
	logic [5:0]  hr_add;
	logic        min_borrow;
	logic [6:0]  min_sub;
	logic [5:0]  hr_take;
	logic        hr_borrow;
	logic [5:0]  hr_sub;
	logic [12:0] year_rem_full;

	logic [4:0]  mo_sum;
	logic        mo_wrap;
	logic [4:0]  mo_add;
	logic        mo_borrow;
	logic [4:0]  mo_sub;
	logic [7:0]  yr_sum;
	logic [7:0]  yr_add;
	logic [7:0]  yr_take;
	logic        yr_borrow;
	logic [7:0]  yr_sub;
	cta_time_t   tm_end;

	// Next month, with the year wrapping from 99 to 0.
	function automatic cta_time_t month_up(input cta_time_t t);
		cta_time_t r;
		r = t;
		if (t.month < 4'd12) begin
			r.month = t.month + 4'd1;
		end else begin
			r.month = 4'd1;
			r.year  = (t.year >= 7'd99) ? 7'd0 : t.year + 7'd1;
		end
		return r;
	endfunction

	// Previous month, with the year wrapping from 0 to 99.
	function automatic cta_time_t month_down(input cta_time_t t);
		cta_time_t r;
		r = t;
		if (t.month > 4'd1) begin
			r.month = t.month - 4'd1;
		end else begin
			r.month = 4'd12;
			r.year  = (t.year == 7'd0) ? 7'd99 : t.year - 7'd1;
		end
		return r;
	endfunction

	// Move the day by n with at most one carry or borrow into the month.
	// Adding wraps by the current month's length; subtracting steps back a
	// month first and then adds that month's length.
	function automatic cta_time_t day_step(input cta_time_t t, input logic sub,
		input logic [4:0] n);
		cta_time_t  r;
		logic [6:0] sum;
		logic [6:0] over;
		logic [6:0] back;
		logic [4:0] len;
		logic [4:0] len_prev;
		r        = t;
		sum      = {1'b0, t.day} + {2'b00, n};
		len      = month_len(t.month, t.year);
		over     = sum - {2'b00, len};
		len_prev = 5'd0;
		back     = 7'd0;
		if (!sub) begin
			if (sum <= {2'b00, len}) begin
				r.day = sum[5:0];
			end else begin
				r     = month_up(t);
				r.day = over[5:0];
			end
		end else begin
			if (t.day > {1'b0, n}) begin
				r.day = t.day - {1'b0, n};
			end else begin
				r        = month_down(t);
				len_prev = month_len(r.month, r.year);
				back     = {1'b0, t.day} + {2'b00, len_prev} - {2'b00, n};
				r.day    = back[5:0];
			end
		end
		return r;
	endfunction

	// Stage enables: a stage loads when it is empty or its successor moves.
	assign en_s4      = !v_s4 || !res_stall;
	assign en_s3      = !v_s3 || en_s4;
	assign en_s2      = !v_s2 || en_s3;
	assign en_s1      = !v_s1 || en_s2;
	assign work_stall = !en_s1;

	// Stage 1: minute and hour with one carry or borrow into the day.
	assign min_sum  = {1'b0, work.tm.minute} + {1'b0, work.part_minute};
	assign min_wrap = min_sum >= 7'd60;
	assign min_add  = min_wrap ? min_sum - 7'd60 : min_sum;
	assign hr_sum   = {1'b0, work.tm.hour} + {1'b0, work.part_hour} + {5'd0, min_wrap};
	assign hr_wrap  = hr_sum >= 6'd24;
	assign hr_add   = hr_wrap ? hr_sum - 6'd24 : hr_sum;

	assign min_borrow = work.tm.minute < work.part_minute;
	assign min_sub    = min_borrow ?
		{1'b0, work.tm.minute} + 7'd60 - {1'b0, work.part_minute} :
		{1'b0, work.tm.minute} - {1'b0, work.part_minute};
	assign hr_take    = {1'b0, work.part_hour} + {5'd0, min_borrow};
	assign hr_borrow  = {1'b0, work.tm.hour} < hr_take;
	assign hr_sub     = hr_borrow ? {1'b0, work.tm.hour} + 6'd24 - hr_take :
		{1'b0, work.tm.hour} - hr_take;

	// Year part modulo 100, from its precomputed hundreds.
	assign year_rem_full = work.year_quo - ({6'd0, work.year_hun} * 13'd100);

	always_comb begin
		st1_next.mode        = work.mode;
		st1_next.apply       = work.apply;
		st1_next.start_valid = work.start_valid;
		st1_next.range_error = work.range_error;
		st1_next.tm          = work.tm;
		st1_next.carry       = 1'b0;
		st1_next.part_day    = work.part_day;
		st1_next.part_month  = work.part_month;
		st1_next.year_rem    = year_rem_full[6:0];
		if (work.apply) begin
			if (work.mode == MODE_SUB) begin
				st1_next.tm.minute = min_sub[5:0];
				st1_next.tm.hour   = hr_sub[4:0];
				st1_next.carry     = hr_borrow;
			end else begin
				st1_next.tm.minute = min_add[5:0];
				st1_next.tm.hour   = hr_add[4:0];
				st1_next.carry     = hr_wrap;
			end
		end
	end

	// Stage 2: the single day carried or borrowed from the hour.
	always_comb begin
		st2_next = st_s1;
		if (st_s1.apply && st_s1.carry) begin
			st2_next.tm = day_step(st_s1.tm, st_s1.mode == MODE_SUB, 5'd1);
		end
	end

	// Stage 3: the day part of the interval, applied even when it is zero.
	always_comb begin
		st3_next = st_s2;
		if (st_s2.apply) begin
			st3_next.tm = day_step(st_s2.tm, st_s2.mode == MODE_SUB, st_s2.part_day);
		end
	end

	// Stage 4: month part with one year carry or borrow, then the year part.
	assign mo_sum    = {1'b0, st_s3.tm.month} + {1'b0, st_s3.part_month};
	assign mo_wrap   = mo_sum > 5'd12;
	assign mo_add    = mo_wrap ? mo_sum - 5'd12 : mo_sum;
	assign yr_sum    = {1'b0, st_s3.tm.year} + {1'b0, st_s3.year_rem} + {7'd0, mo_wrap};
	assign yr_add    = (yr_sum >= 8'd100) ? yr_sum - 8'd100 : yr_sum;

	assign mo_borrow = st_s3.tm.month <= st_s3.part_month;
	assign mo_sub    = mo_borrow ?
		{1'b0, st_s3.tm.month} + 5'd12 - {1'b0, st_s3.part_month} :
		{1'b0, st_s3.tm.month} - {1'b0, st_s3.part_month};
	assign yr_take   = {1'b0, st_s3.year_rem} + {7'd0, mo_borrow};
	assign yr_borrow = {1'b0, st_s3.tm.year} < yr_take;
	assign yr_sub    = yr_borrow ? {1'b0, st_s3.tm.year} + 8'd100 - yr_take :
		{1'b0, st_s3.tm.year} - yr_take;

	always_comb begin
		tm_end = st_s3.tm;
		if (st_s3.apply) begin
			if (st_s3.mode == MODE_SUB) begin
				tm_end.month = mo_sub[3:0];
				tm_end.year  = yr_sub[6:0];
			end else begin
				tm_end.month = mo_add[3:0];
				tm_end.year  = yr_add[6:0];
			end
			// A day that ran past 31 saturates.
			if (st_s3.tm.day > 6'd31) begin
				tm_end.day = 6'd31;
			end
		end
		res_next.new_minute  = tm_end.minute;
		res_next.new_hour    = tm_end.hour;
		res_next.new_day     = tm_end.day[4:0];
		res_next.new_month   = tm_end.month;
		res_next.new_year    = tm_end.year;
		res_next.start_valid = st_s3.start_valid;
		res_next.range_error = st_s3.range_error;
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= work_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			st_s1 <= st1_next;
		end
		if (en_s2) begin
			st_s2 <= st2_next;
		end
		if (en_s3) begin
			st_s3 <= st3_next;
		end
		if (en_s4) begin
			res_s4 <= res_next;
		end
	end

	assign res_valid = v_s4;
	assign res       = res_s4;

	`CTA_ASSERT_NEXT(a_stage_advance, v_s1 && en_s2, v_s2, "transaction lost between stepping stages")
	`CTA_ASSERT_NOW(a_mid_time, v_s2 && st_s2.apply, st_s2.tm.minute < 6'd60 && st_s2.tm.hour < 5'd24 && st_s2.tm.day >= 6'd1 && st_s2.tm.day <= 6'd31, "time out of range after day carry")
	`CTA_ASSERT_NOW(a_result_range, res_valid && res.start_valid && !res.range_error, res.new_minute < 6'd60 && res.new_hour < 5'd24 && res.new_day != 5'd0 && res.new_month >= 4'd1 && res.new_month <= 4'd12 && res.new_year <= 7'd99, "result time out of range")

endmodule

// ----- rtl/calendar_time_add_subtract_unit.sv -----
// Calendar interval adder and subtractor for years 2000 to 2099. Each request transaction
// carries a start time and an interval in minutes, hours, days or months, and produces one
// result transaction with the shifted time, a start-validity flag and a range-error flag; a
// range error or an invalid start returns the start fields unchanged. The block takes one
// transaction per clock cycle unless the result side stalls, and passes each through
// two stages that take the interval apart with reciprocal multiplies, then four that step
// minute and hour, the carried day, the day part, and month with year. Stall on the result
// side propagates backward through the stage enables in the same cycle, and an empty stage
// keeps filling while later ones wait, so bubbles are squeezed out. Beyond the pipeline
// registers there is no stored state, and there is no start-up delay after reset.
module calendar_time_add_subtract_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  cta_pkg::cta_cmd_t cmd,
	output logic              res_valid,
	input  logic              res_stall,
	output cta_pkg::cta_res_t res
);
	import cta_pkg::*;

	logic      work_valid;
	logic      work_stall;
	cta_work_t work;

	// Interval decomposition and range checks.
	cta_split u_split (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.work_valid (work_valid),
		.work_stall (work_stall),
		.work       (work)
	);

	// Field-by-field calendar stepping.
	cta_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.work_valid (work_valid),
		.work_stall (work_stall),
		.work       (work),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

endmodule
